>>> rtl/core/svm_pkg.sv
// shared types, opcodes and the byte sign-extend helper of the stack machine execute unit
package svm_pkg;

  typedef enum logic [1:0] {
    FN_EXEC    = 2'd0,
    FN_WRITE   = 2'd1,
    FN_READ    = 2'd2,
    FN_RESTART = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_EXIT  = 3'd1,
    ST_BADOP = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_HOST  = 3'd4
  } status_t;

  // instruction classes decided in the front end
  typedef enum logic [3:0] {
    CL_NONE,
    CL_BAD,
    CL_HOST,
    CL_EXIT,
    CL_DIV,
    CL_ALU,
    CL_LOAD,
    CL_STORE,
    CL_CTRL
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_D1,
    S_D2,
    S_DIV,
    S_FIN
  } back_state_t;

  typedef struct packed {
    func_t       func;
    logic [5:0]  opcode;
    logic [31:0] operand;
    logic [15:0] mem_addr;
    logic [31:0] mem_data;
    cls_t        cls;
  } cmd_t;

  localparam logic [5:0] OP_LEA  = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_JSR  = 6'd3;
  localparam logic [5:0] OP_JZ   = 6'd4;
  localparam logic [5:0] OP_JNZ  = 6'd5;
  localparam logic [5:0] OP_ENT  = 6'd6;
  localparam logic [5:0] OP_ADJ  = 6'd7;
  localparam logic [5:0] OP_LEV  = 6'd8;
  localparam logic [5:0] OP_LI   = 6'd9;
  localparam logic [5:0] OP_LC   = 6'd10;
  localparam logic [5:0] OP_SI   = 6'd11;
  localparam logic [5:0] OP_SC   = 6'd12;
  localparam logic [5:0] OP_PSH  = 6'd13;
  localparam logic [5:0] OP_OR   = 6'd14;
  localparam logic [5:0] OP_XOR  = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_EQ   = 6'd17;
  localparam logic [5:0] OP_NE   = 6'd18;
  localparam logic [5:0] OP_LT   = 6'd19;
  localparam logic [5:0] OP_GT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GE   = 6'd22;
  localparam logic [5:0] OP_SHL  = 6'd23;
  localparam logic [5:0] OP_SHR  = 6'd24;
  localparam logic [5:0] OP_ADD  = 6'd25;
  localparam logic [5:0] OP_SUB  = 6'd26;
  localparam logic [5:0] OP_MUL  = 6'd27;
  localparam logic [5:0] OP_DIV  = 6'd28;
  localparam logic [5:0] OP_MOD  = 6'd29;
  localparam logic [5:0] OP_HOST_LO = 6'd30;
  localparam logic [5:0] OP_HOST_HI = 6'd36;
  localparam logic [5:0] OP_EXIT = 6'd37;

  function automatic logic [31:0] sx8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

endpackage

>>> rtl/core/svm_fifo.sv
// two-entry word queue used between front and back and on the result side
module svm_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] data_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) data_r[wp_r] <= wdata;
  end

endmodule

>>> rtl/core/svm_front.sv
// front end: classifies incoming words and queues them for the back end
module svm_front
  import svm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_func,
  input  logic [5:0]          in_opcode,
  input  logic signed [31:0]  in_operand,
  input  logic [15:0]         in_mem_addr,
  input  logic signed [31:0]  in_mem_data,
  input  logic                cmd_pop,
  output cmd_t                cmd,
  output logic                cmd_empty
);

  cmd_t dec;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    dec.func     = func_t'(in_func);
    dec.opcode   = in_opcode;
    dec.operand  = in_operand;
    dec.mem_addr = in_mem_addr;
    dec.mem_data = in_mem_data;
    if (func_t'(in_func) != FN_EXEC) dec.cls = CL_NONE;
    else if (in_opcode > OP_EXIT) dec.cls = CL_BAD;
    else if (in_opcode == OP_EXIT) dec.cls = CL_EXIT;
    else if (in_opcode >= OP_HOST_LO && in_opcode <= OP_HOST_HI) dec.cls = CL_HOST;
    else if (in_opcode == OP_DIV || in_opcode == OP_MOD) dec.cls = CL_DIV;
    else if (in_opcode >= OP_OR) dec.cls = CL_ALU;
    else if (in_opcode == OP_LI || in_opcode == OP_LC) dec.cls = CL_LOAD;
    else if (in_opcode == OP_SI || in_opcode == OP_SC) dec.cls = CL_STORE;
    else dec.cls = CL_CTRL;
  end

  svm_fifo #(.W($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (dec),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(q_rdata);

endmodule

>>> rtl/core/svm_back.sv
// back end: machine registers, data memory, sequencer and divider
module svm_back
  import svm_pkg::*;
#(
  parameter int MEM_WORDS  = 16384,
  parameter int PROG_WORDS = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  cmd_t                          cmd,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output logic [$clog2(PROG_WORDS)-1:0] res_pc,
  output logic [31:0]                   res_acc,
  output logic [2:0]                    res_status,
  output logic [31:0]                   res_exit,
  output logic [31:0]                   res_rdata
);

  localparam int WAW = $clog2(MEM_WORDS);
  localparam int AW  = WAW + 2;
  localparam int PW  = $clog2(PROG_WORDS);
  localparam logic [AW-1:0] FOUR  = AW'(4);
  localparam logic [AW-1:0] EIGHT = AW'(8);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rd_q;
  logic            we;
  logic [WAW-1:0]  wa, ra;
  logic [31:0]     wd;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [AW-1:0] sp_r, sp_nxt, fp_r, fp_nxt;
  logic        halted_r, halted_nxt;
  logic [15:0] stack_top_r;
  logic [13:0] start_pc_r;
  logic [31:0] aux_r, aux_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        qneg_r, qneg_nxt, rneg_r, rneg_nxt;

  logic [PW-1:0] pc1, pc2;
  logic [AW-1:0] sp_push;
  logic [31:0]   ma_ext, st_ext, alu_out;
  logic [32:0]   div_t, div_diff;
  logic [31:0]   q_fin, r_fin;
  logic [7:0]    sel_byte;
  logic [31:0]   merged;

  // data memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_top_r <= '0;
      start_pc_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index) start_pc_r <= cfg_data[13:0];
      else stack_top_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      acc_r    <= '0;
      sp_r     <= '0;
      fp_r     <= '0;
      halted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      acc_r    <= acc_nxt;
      sp_r     <= sp_nxt;
      fp_r     <= fp_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    aux_r  <= aux_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    cnt_r  <= cnt_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign pc1      = pc_r + PW'(1);
  assign pc2      = pc_r + PW'(2);
  assign sp_push  = sp_r - FOUR;
  assign ma_ext   = {16'b0, cmd.mem_addr};
  assign st_ext   = {16'b0, stack_top_r};
  assign div_t    = {rem_r, quo_r[31]};
  assign div_diff = div_t - {1'b0, dvs_r};
  assign q_fin    = qneg_r ? -quo_r : quo_r;
  assign r_fin    = rneg_r ? -rem_r : rem_r;

  always_comb begin
    unique case (acc_r[1:0])
      2'd0: sel_byte = rd_q[7:0];
      2'd1: sel_byte = rd_q[15:8];
      2'd2: sel_byte = rd_q[23:16];
      default: sel_byte = rd_q[31:24];
    endcase
  end

  always_comb begin
    merged = rd_q;
    unique case (aux_r[1:0])
      2'd0: merged[7:0]   = acc_r[7:0];
      2'd1: merged[15:8]  = acc_r[7:0];
      2'd2: merged[23:16] = acc_r[7:0];
      default: merged[31:24] = acc_r[7:0];
    endcase
  end

  // left operand from the stack, right operand is the accumulator
  always_comb begin
    unique case (cmd_r.opcode)
      OP_OR:  alu_out = rd_q | acc_r;
      OP_XOR: alu_out = rd_q ^ acc_r;
      OP_AND: alu_out = rd_q & acc_r;
      OP_EQ:  alu_out = {31'b0, rd_q == acc_r};
      OP_NE:  alu_out = {31'b0, rd_q != acc_r};
      OP_LT:  alu_out = {31'b0, $signed(rd_q) < $signed(acc_r)};
      OP_GT:  alu_out = {31'b0, $signed(rd_q) > $signed(acc_r)};
      OP_LE:  alu_out = {31'b0, $signed(rd_q) <= $signed(acc_r)};
      OP_GE:  alu_out = {31'b0, $signed(rd_q) >= $signed(acc_r)};
      OP_SHL: alu_out = rd_q << acc_r[4:0];
      OP_SHR: alu_out = $signed(rd_q) >>> acc_r[4:0];
      OP_ADD: alu_out = rd_q + acc_r;
      OP_SUB: alu_out = rd_q - acc_r;
      OP_MUL: alu_out = rd_q * acc_r;
      default: alu_out = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    sp_nxt     = sp_r;
    fp_nxt     = fp_r;
    halted_nxt = halted_r;
    aux_nxt    = aux_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    qneg_nxt   = qneg_r;
    rneg_nxt   = rneg_r;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    ra         = '0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_status = halted_r ? ST_EXIT : ST_RUN;
    res_exit   = '0;
    res_rdata  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          unique case (cmd.func)
            FN_WRITE: begin
              we = 1'b1;
              wa = ma_ext[AW-1:2];
              wd = cmd.mem_data;
              res_push = 1'b1;
            end
            FN_READ: begin
              ra = ma_ext[AW-1:2];
              state_nxt = S_D1;
            end
            FN_RESTART: begin
              pc_nxt     = PW'({18'b0, start_pc_r});
              sp_nxt     = st_ext[AW-1:0];
              fp_nxt     = st_ext[AW-1:0];
              acc_nxt    = '0;
              halted_nxt = 1'b0;
              res_status = ST_RUN;
              res_push   = 1'b1;
            end
            default: begin
              if (halted_r) begin
                res_push = 1'b1;
              end else begin
                unique case (cmd.cls)
                  CL_HOST: begin
                    res_status = ST_HOST;
                    res_push   = 1'b1;
                  end
                  CL_EXIT, CL_ALU, CL_STORE: begin
                    ra = sp_r[AW-1:2];
                    state_nxt = S_D1;
                  end
                  CL_DIV: begin
                    if (acc_r == '0) begin
                      res_status = ST_DIVZ;
                      res_push   = 1'b1;
                    end else begin
                      ra = sp_r[AW-1:2];
                      state_nxt = S_D1;
                    end
                  end
                  CL_LOAD: begin
                    ra = acc_r[AW-1:2];
                    state_nxt = S_D1;
                  end
                  CL_CTRL: begin
                    res_push = 1'b1;
                    unique case (cmd.opcode)
                      OP_LEA: begin
                        acc_nxt = {{(32-AW){1'b0}},
                                   fp_r + {cmd.operand[AW-3:0], 2'b00}};
                        pc_nxt = pc2;
                      end
                      OP_IMM: begin
                        acc_nxt = cmd.operand;
                        pc_nxt  = pc2;
                      end
                      OP_JMP: pc_nxt = cmd.operand[PW-1:0];
                      OP_JSR: begin
                        we = 1'b1;
                        wa = sp_push[AW-1:2];
                        wd = {{(32-PW){1'b0}}, pc2};
                        sp_nxt = sp_push;
                        pc_nxt = cmd.operand[PW-1:0];
                      end
                      OP_JZ:  pc_nxt = (acc_r == '0) ? cmd.operand[PW-1:0] : pc2;
                      OP_JNZ: pc_nxt = (acc_r != '0) ? cmd.operand[PW-1:0] : pc2;
                      OP_ENT: begin
                        we = 1'b1;
                        wa = sp_push[AW-1:2];
                        wd = {{(32-AW){1'b0}}, fp_r};
                        fp_nxt = sp_push;
                        sp_nxt = sp_push - {cmd.operand[AW-3:0], 2'b00};
                        pc_nxt = pc2;
                      end
                      OP_ADJ: begin
                        sp_nxt = sp_r + {cmd.operand[AW-3:0], 2'b00};
                        pc_nxt = pc2;
                      end
                      OP_PSH: begin
                        we = 1'b1;
                        wa = sp_push[AW-1:2];
                        wd = acc_r;
                        sp_nxt = sp_push;
                        pc_nxt = pc1;
                      end
                      default: begin
                        // frame leave: saved frame pointer sits at the frame base
                        res_push  = 1'b0;
                        ra        = fp_r[AW-1:2];
                        state_nxt = S_D1;
                      end
                    endcase
                  end
                  default: begin
                    res_status = ST_BADOP;
                    res_push   = 1'b1;
                  end
                endcase
              end
            end
          endcase
        end
      end

      S_D1: begin
        state_nxt = S_IDLE;
        if (cmd_r.func == FN_READ) begin
          res_rdata = rd_q;
          res_push  = 1'b1;
        end else begin
          unique case (cmd_r.cls)
            CL_EXIT: begin
              halted_nxt = 1'b1;
              res_exit   = rd_q;
              res_status = ST_EXIT;
              res_push   = 1'b1;
            end
            CL_LOAD: begin
              acc_nxt  = (cmd_r.opcode == OP_LI) ? rd_q : sx8(sel_byte);
              pc_nxt   = pc1;
              res_push = 1'b1;
            end
            CL_STORE: begin
              sp_nxt = sp_r + FOUR;
              if (cmd_r.opcode == OP_SI) begin
                we = 1'b1;
                wa = rd_q[AW-1:2];
                wd = acc_r;
                pc_nxt   = pc1;
                res_push = 1'b1;
              end else begin
                ra        = rd_q[AW-1:2];
                aux_nxt   = rd_q;
                state_nxt = S_D2;
              end
            end
            CL_ALU: begin
              sp_nxt   = sp_r + FOUR;
              acc_nxt  = alu_out;
              pc_nxt   = pc1;
              res_push = 1'b1;
            end
            CL_DIV: begin
              sp_nxt   = sp_r + FOUR;
              quo_nxt  = rd_q[31] ? -rd_q : rd_q;
              dvs_nxt  = acc_r[31] ? -acc_r : acc_r;
              rem_nxt  = '0;
              cnt_nxt  = 5'd31;
              qneg_nxt = rd_q[31] ^ acc_r[31];
              rneg_nxt = rd_q[31];
              state_nxt = S_DIV;
            end
            default: begin
              // frame leave, first word is the caller frame pointer
              sp_nxt    = fp_r + FOUR;
              fp_nxt    = rd_q[AW-1:0];
              ra        = fp_r[AW-1:2] + WAW'(1);
              aux_nxt   = {{(32-AW){1'b0}}, fp_r + EIGHT};
              state_nxt = S_D2;
            end
          endcase
        end
      end

      S_D2: begin
        state_nxt = S_IDLE;
        res_push  = 1'b1;
        if (cmd_r.cls == CL_STORE) begin
          we = 1'b1;
          wa = aux_r[AW-1:2];
          wd = merged;
          acc_nxt = sx8(acc_r[7:0]);
          pc_nxt  = pc1;
        end else begin
          pc_nxt = rd_q[PW-1:0];
          sp_nxt = aux_r[AW-1:0];
        end
      end

      S_DIV: begin
        // one quotient bit per cycle, restoring
        if (!div_diff[32]) begin
          rem_nxt = div_diff[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = div_t[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = S_FIN;
      end

      default: begin
        state_nxt = S_IDLE;
        acc_nxt   = (cmd_r.opcode == OP_DIV) ? q_fin : r_fin;
        pc_nxt    = pc1;
        res_push  = 1'b1;
      end
    endcase

    res_pc  = pc_nxt;
    res_acc = acc_nxt;
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE))
    else $error("command taken while busy");

  a_halt_from_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !$past(halted_r)) |-> $past(state_r == S_D1 && cmd_r.cls == CL_EXIT))
    else $error("halt without exit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != '0))
    else $error("divider running on zero divisor");
`endif

endmodule

>>> rtl/core/stack_vm_execute_unit_top.sv
// execute unit of an accumulator plus stack machine: front, back and result queue
// register-only words finish in S_IDLE, one data memory read adds S_D1, frame leave
// and byte store add S_D1 and S_D2, divide and modulo add S_D1, S_DIV and S_FIN
// throughput: one word at a time in the back end, paced by the registered data
// memory read and the one-bit-per-cycle divider; queues of two on each side
// reset is synchronous active low: machine registers and queues clear, data
// memory is not cleared and holds undefined words until written
module stack_vm_execute_unit_top
  import svm_pkg::*;
#(
  parameter int MEM_WORDS  = 16384,
  parameter int PROG_WORDS = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_func,
  input  logic [5:0]                    in_opcode,
  input  logic signed [31:0]            in_operand,
  input  logic [15:0]                   in_mem_addr,
  input  logic signed [31:0]            in_mem_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [$clog2(PROG_WORDS)-1:0] out_next_pc,
  output logic signed [31:0]            out_acc,
  output logic [2:0]                    out_status,
  output logic signed [31:0]            out_exit_value,
  output logic signed [31:0]            out_read_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int PW = $clog2(PROG_WORDS);
  localparam int RW = PW + 32 + 3 + 32 + 32;

  cmd_t          cmd;
  logic          cmd_empty, cmd_pop;
  logic          res_full, res_push;
  logic [PW-1:0] res_pc;
  logic [31:0]   res_acc, res_exit, res_rdata;
  logic [2:0]    res_status;
  logic [RW-1:0] res_word;

  assign cfg_ready = 1'b1;

  svm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_func     (in_func),
    .in_opcode   (in_opcode),
    .in_operand  (in_operand),
    .in_mem_addr (in_mem_addr),
    .in_mem_data (in_mem_data),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .cmd_empty   (cmd_empty)
  );

  svm_back #(.MEM_WORDS(MEM_WORDS), .PROG_WORDS(PROG_WORDS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_pc     (res_pc),
    .res_acc    (res_acc),
    .res_status (res_status),
    .res_exit   (res_exit),
    .res_rdata  (res_rdata)
  );

  svm_fifo #(.W(RW)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_pc, res_acc, res_status, res_exit, res_rdata}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_word),
    .empty (out_empty)
  );

  assign {out_next_pc, out_acc, out_status, out_exit_value, out_read_data} = res_word;

endmodule

>>> bench/stack_vm_execute_unit_top_tb.sv
// testbench of the stack machine execute unit: directed and random programs checked against a predictor
`timescale 1ns / 100ps

module stack_vm_execute_unit_top_tb;
  import svm_pkg::*;

  localparam int  CLK_PERIOD    = 20;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  RANDOM_ITEMS  = 300;
  localparam bit  REG_STACK_TOP = 1'b0;
  localparam bit  REG_START_PC  = 1'b1;

  typedef struct {
    func_t       func;
    logic [5:0]  opcode;
    logic [31:0] operand;
    logic [15:0] mem_addr;
    logic [31:0] mem_data;
  } vm_cmd_t;

  typedef struct {
    logic [13:0] next_pc;
    logic [31:0] acc;
    logic [2:0]  status;
    logic [31:0] exit_value;
    logic [31:0] read_data;
  } vm_res_t;

  class vm_scoreboard;
    logic [15:0] stack_top;
    logic [13:0] start_pc;
    logic [13:0] pc;
    logic [31:0] ax;
    logic [15:0] sp;
    logic [15:0] fp;
    bit          halted;
    logic [31:0] mem[16384];
    bit          written[16384];
    vm_res_t     pending[$];
    int          mismatches;

    function new();
      stack_top = 0;
      start_pc = 0;
      pc = 0;
      ax = 0;
      sp = 0;
      fp = 0;
      halted = 0;
      mismatches = 0;
    endfunction

    function void set_reg(bit idx, logic [15:0] data);
      if (idx == REG_STACK_TOP) stack_top = data;
      else start_pc = data[13:0];
    endfunction

    function bit hole(logic [15:0] a);
      return !written[a[15:2]];
    endfunction

    // word that the command would read but that holds nothing defined yet
    function bit unread_word(vm_cmd_t c, output logic [15:0] a);
      a = sp;
      if (c.func == FN_READ) begin
        a = c.mem_addr;
        return hole(a);
      end
      if (c.func != FN_EXEC || halted) return 0;
      case (c.opcode)
        OP_EXIT, OP_SI: a = sp;
        OP_LEV: a = hole(fp) ? fp : fp + 16'd4;
        OP_LI, OP_LC: a = ax[15:0];
        OP_SC: a = hole(sp) ? sp : mem[sp[15:2]][15:0];
        default: begin
          if (c.opcode < OP_OR || c.opcode > OP_MOD) return 0;
          if ((c.opcode == OP_DIV || c.opcode == OP_MOD) && ax == 0) return 0;
          a = sp;
        end
      endcase
      return hole(a);
    endfunction

    function logic [31:0] pop_word();
      logic [31:0] v;
      v = mem[sp[15:2]];
      sp = sp + 16'd4;
      return v;
    endfunction

    function void push_word(logic [31:0] v);
      sp = sp - 16'd4;
      mem[sp[15:2]] = v;
      written[sp[15:2]] = 1;
    endfunction

    function logic [2:0] execute(vm_cmd_t c, output logic [31:0] exitv);
      logic [13:0] pc1, pc2;
      logic [15:0] off, a;
      logic [31:0] l, w, r;
      logic [4:0]  n;
      logic [5:0]  op;
      pc1 = pc + 14'd1;
      pc2 = pc + 14'd2;
      off = {c.operand[13:0], 2'b00};
      op = c.opcode;
      exitv = 0;
      if (halted) return ST_EXIT;
      if (op >= OP_HOST_LO && op <= OP_HOST_HI) return ST_HOST;
      if (op > OP_EXIT) return ST_BADOP;
      if (op == OP_EXIT) begin
        exitv = mem[sp[15:2]];
        halted = 1;
        return ST_EXIT;
      end
      if ((op == OP_DIV || op == OP_MOD) && ax == 0) return ST_DIVZ;
      case (op)
        OP_LEA: begin ax = {16'd0, fp + off}; pc = pc2; end
        OP_IMM: begin ax = c.operand; pc = pc2; end
        OP_JMP: pc = c.operand[13:0];
        OP_JSR: begin push_word({18'd0, pc2}); pc = c.operand[13:0]; end
        OP_JZ:  pc = (ax == 0) ? c.operand[13:0] : pc2;
        OP_JNZ: pc = (ax != 0) ? c.operand[13:0] : pc2;
        OP_ENT: begin
          push_word({16'd0, fp});
          fp = sp;
          sp = sp - off;
          pc = pc2;
        end
        OP_ADJ: begin sp = sp + off; pc = pc2; end
        OP_LEV: begin
          sp = fp;
          l = pop_word();
          fp = l[15:0];
          l = pop_word();
          pc = l[13:0];
        end
        OP_LI: begin ax = mem[ax[15:2]]; pc = pc1; end
        OP_LC: begin
          w = mem[ax[15:2]] >> (ax[1:0] * 8);
          ax = {{24{w[7]}}, w[7:0]};
          pc = pc1;
        end
        OP_SI: begin
          l = pop_word();
          a = l[15:0];
          mem[a[15:2]] = ax;
          written[a[15:2]] = 1;
          pc = pc1;
        end
        OP_SC: begin
          l = pop_word();
          a = l[15:0];
          w = mem[a[15:2]];
          w[a[1:0]*8 +: 8] = ax[7:0];
          mem[a[15:2]] = w;
          ax = {{24{ax[7]}}, ax[7:0]};
          pc = pc1;
        end
        OP_PSH: begin push_word(ax); pc = pc1; end
        default: begin
          l = pop_word();
          n = ax[4:0];
          case (op)
            OP_OR:  r = l | ax;
            OP_XOR: r = l ^ ax;
            OP_AND: r = l & ax;
            OP_EQ:  r = {31'd0, l == ax};
            OP_NE:  r = {31'd0, l != ax};
            OP_LT:  r = {31'd0, $signed(l) < $signed(ax)};
            OP_GT:  r = {31'd0, $signed(l) > $signed(ax)};
            OP_LE:  r = {31'd0, $signed(l) <= $signed(ax)};
            OP_GE:  r = {31'd0, $signed(l) >= $signed(ax)};
            OP_SHL: r = l << n;
            OP_SHR: r = $signed(l) >>> n;
            OP_ADD: r = l + ax;
            OP_SUB: r = l - ax;
            OP_MUL: r = l * ax;
            // 64-bit math keeps minimum over minus one defined
            OP_DIV: r = 32'(longint'($signed(l)) / longint'($signed(ax)));
            default: r = 32'(longint'($signed(l)) % longint'($signed(ax)));
          endcase
          ax = r;
          pc = pc1;
        end
      endcase
      return ST_RUN;
    endfunction

    function void note_input(vm_cmd_t c);
      vm_res_t e;
      e.exit_value = 0;
      e.read_data = 0;
      e.status = halted ? ST_EXIT : ST_RUN;
      case (c.func)
        FN_EXEC: e.status = execute(c, e.exit_value);
        FN_WRITE: begin
          mem[c.mem_addr[15:2]] = c.mem_data;
          written[c.mem_addr[15:2]] = 1;
        end
        FN_READ: e.read_data = mem[c.mem_addr[15:2]];
        default: begin
          pc = start_pc;
          sp = stack_top;
          fp = stack_top;
          ax = 0;
          halted = 0;
          e.status = ST_RUN;
        end
      endcase
      e.next_pc = pc;
      e.acc = ax;
      pending.push_back(e);
    endfunction

    function void check_result(vm_res_t got);
      vm_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, pc %0d", got.next_pc);
        return;
      end
      e = pending.pop_front();
      if (got.next_pc !== e.next_pc || got.acc !== e.acc || got.status !== e.status ||
          got.exit_value !== e.exit_value || got.read_data !== e.read_data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp pc %0d acc %h st %0d exit %h rd %h / got %0d %h %0d %h %h",
                   e.next_pc, e.acc, e.status, e.exit_value, e.read_data,
                   got.next_pc, got.acc, got.status, got.exit_value, got.read_data);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [1:0]         in_func;
  logic [5:0]         in_opcode;
  logic signed [31:0] in_operand;
  logic [15:0]        in_mem_addr;
  logic signed [31:0] in_mem_data;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [13:0]        out_next_pc;
  logic signed [31:0] out_acc;
  logic [2:0]         out_status;
  logic signed [31:0] out_exit_value;
  logic signed [31:0] out_read_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;

  vm_scoreboard sb;
  int           send_idle_pct;
  int           pop_stall_pct;
  int           cycles = 0;

  stack_vm_execute_unit_top u_dut (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_opcode, .in_operand,
    .in_mem_addr, .in_mem_data, .out_empty, .out_pop, .out_next_pc, .out_acc,
    .out_status, .out_exit_value, .out_read_data, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check on a pop handshake, then pick the next pop
  always @(posedge clk) begin
    vm_res_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.next_pc = out_next_pc;
      got.acc = out_acc;
      got.status = out_status;
      got.exit_value = out_exit_value;
      got.read_data = out_read_data;
      sb.check_result(got);
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic send_word(vm_cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_func <= c.func;
    in_opcode <= c.opcode;
    in_operand <= c.operand;
    in_mem_addr <= c.mem_addr;
    in_mem_data <= c.mem_data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(c);
  endtask

  // fill any undefined word the command would read before sending it
  task automatic issue(vm_cmd_t c);
    vm_cmd_t fill;
    logic [15:0] a;
    while (sb.unread_word(c, a)) begin
      fill.func = FN_WRITE;
      fill.opcode = 6'($urandom);
      fill.operand = $urandom;
      fill.mem_addr = a;
      fill.mem_data = ($urandom_range(1) == 0) ? $urandom_range(0, 65535) : $urandom;
      send_word(fill);
    end
    send_word(c);
  endtask

  task automatic exec(logic [5:0] op, logic [31:0] opnd);
    vm_cmd_t c;
    c.func = FN_EXEC;
    c.opcode = op;
    c.operand = opnd;
    c.mem_addr = 16'($urandom);
    c.mem_data = $urandom;
    issue(c);
  endtask

  task automatic loader(func_t f, logic [15:0] a, logic [31:0] d);
    vm_cmd_t c;
    c.func = f;
    c.opcode = 6'($urandom);
    c.operand = $urandom;
    c.mem_addr = a;
    c.mem_data = d;
    issue(c);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32)) - 16;
    endcase
  endfunction

  task automatic random_word();
    int r;
    int w;
    logic [5:0] op;
    r = $urandom_range(99);
    if (r < 3 || (sb.halted && r < 50)) begin
      loader(FN_RESTART, 16'($urandom), $urandom);
    end else if (r < 9) begin
      loader(FN_WRITE, 16'($urandom), $urandom);
    end else if (r < 14) begin
      loader(FN_READ, 16'($urandom), $urandom);
    end else begin
      w = $urandom_range(99);
      if (w < 85) op = 6'($urandom_range(OP_LEA, OP_MOD));
      else if (w < 88) op = OP_EXIT;
      else if (w < 94) op = 6'($urandom_range(OP_HOST_LO, OP_HOST_HI));
      else op = 6'($urandom_range(OP_EXIT + 1, 63));
      exec(op, pick_operand());
    end
  endtask

  initial begin
    int idle_mode[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{24, 24}};
    sb = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_func = FN_EXEC;
    in_opcode = 0;
    in_operand = 0;
    in_mem_addr = 0;
    in_mem_data = 0;
    cfg_valid = 1'b0;
    cfg_index = REG_STACK_TOP;
    cfg_data = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of the pointers and the arithmetic corners
    write_reg(REG_STACK_TOP, 16'd65532);
    write_reg(REG_START_PC, 16'd16383);
    loader(FN_RESTART, 0, 0);
    exec(OP_IMM, 32'h8000_0000);
    exec(OP_PSH, 0);
    exec(OP_IMM, 32'hFFFF_FFFF);
    exec(OP_DIV, 0);
    exec(OP_PSH, 0);
    exec(OP_IMM, 0);
    exec(OP_MOD, 0);
    exec(OP_IMM, 32'd33);
    exec(OP_SHR, 0);
    exec(OP_ENT, 32'd2);
    exec(OP_LEA, 32'hFFFF_FFFF);
    exec(OP_SC, 0);
    exec(OP_JSR, 32'd16383);
    exec(OP_LEV, 0);
    exec(OP_HOST_LO, 0);
    exec(6'd63, 0);
    exec(OP_EXIT, 0);
    exec(OP_IMM, 32'd5);
    loader(FN_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    loader(FN_READ, 16'hFFFF, 0);
    loader(FN_RESTART, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      repeat (40) @(posedge clk);
      send_idle_pct = idle_mode[ph][0];
      pop_stall_pct = idle_mode[ph][1];
      case (ph)
        0: begin end
        1: begin write_reg(REG_STACK_TOP, 0); write_reg(REG_START_PC, 0); end
        default: begin
          write_reg(REG_STACK_TOP, 16'($urandom_range(0, 16383) * 4));
          write_reg(REG_START_PC, 16'($urandom_range(0, 16383)));
        end
      endcase
      loader(FN_RESTART, 0, 0);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        if (ph == 1 && k == RANDOM_ITEMS / 2) drain();
        random_word();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
